[hdl/prer_pkg.sv]
package prer_pkg;

	localparam int FAMILIES       = 8;
	localparam int COUNTER_KINDS  = 5;
	localparam int NO_DESCRIPTOR  = 16;
	localparam int RING_DEPTH_DEF = 16;
	localparam int MAX_DESC_DEF   = 16;

	localparam int REQ_W      = 2;
	localparam int FAM_W      = 3;
	localparam int DESC_W     = 5;
	localparam int DUR_W      = 32;
	localparam int PAYLOAD_W  = 64;
	localparam int KIND_W     = 3;
	localparam int CELL_IDX_W = 8;
	localparam int RESULT_W   = 3;
	localparam int CNT_W      = 32;
	localparam int SUM_W      = 64;
	localparam int HW_W       = 5;
	localparam int CAP_CFG_W  = 5;
	localparam int RES_CFG_W  = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;

	localparam logic [CAP_CFG_W-1:0] CAPACITY_RESET = 5'd16;
	localparam logic [RES_CFG_W-1:0] RESERVE_RESET  = 4'd2;

	typedef enum logic [REQ_W-1:0] {
		REQ_EMIT,
		REQ_POP,
		REQ_READ_CNT,
		REQ_READ_CELL
	} req_t;

	typedef enum logic [RESULT_W-1:0] {
		RES_EMITTED,
		RES_AGGREGATED,
		RES_DROPPED,
		RES_POPPED,
		RES_EMPTY,
		RES_READ_DONE
	} result_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_OBS_MODE,
		CFG_CAPACITY,
		CFG_RESERVE,
		CFG_DESC_COUNT
	} cfg_reg_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_OBSERVED,
		KIND_EMITTED,
		KIND_AGGREGATED,
		KIND_DROPPED,
		KIND_UPDATES
	} kind_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} state_t;

	typedef struct packed {
		logic clear;
		logic capture;
		logic commit;
	} dp_cmd_t;

	typedef struct packed {
		logic clear_done;
	} dp_status_t;

endpackage

[hdl/prer_ctrl.sv]
module prer_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  prer_pkg::dp_status_t status,
	output prer_pkg::dp_cmd_t    cmd
);
	import prer_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	// result register free now or emptied by the transfer at this edge
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (status.clear_done) state_d = ST_IDLE;
			ST_IDLE:  if (in_valid) state_d = ST_EXEC;
			ST_EXEC:  if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: cmd.clear = 1'b1;
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_EXEC:  cmd.commit = out_free;
			default:  cmd = '0;
		endcase
	end

`ifndef ASSERT_OFF
	a_result_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.commit))
		else $error("result appeared without a commit");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> !in_ready)
		else $error("second request taken while one is in flight");

	a_no_result_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> !out_valid_q && !cmd.commit)
		else $error("result activity during table clear");
`endif

endmodule

[hdl/prer_dp.sv]
module prer_dp #(
	parameter int RING_DEPTH      = prer_pkg::RING_DEPTH_DEF,
	parameter int MAX_DESCRIPTORS = prer_pkg::MAX_DESC_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  prer_pkg::dp_cmd_t                 cmd,
	output prer_pkg::dp_status_t              status,
	input  logic                              cfg_we,
	input  logic [prer_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [prer_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic [prer_pkg::REQ_W-1:0]        req_type,
	input  logic [prer_pkg::FAM_W-1:0]        family,
	input  logic                              lifecycle,
	input  logic [prer_pkg::DESC_W-1:0]       desc_index,
	input  logic [prer_pkg::DUR_W-1:0]        duration,
	input  logic [prer_pkg::PAYLOAD_W-1:0]    payload,
	input  logic [prer_pkg::KIND_W-1:0]       counter_sel,
	input  logic [prer_pkg::CELL_IDX_W-1:0]   cell_index,
	output logic [prer_pkg::RESULT_W-1:0]     result_code,
	output logic [prer_pkg::PAYLOAD_W-1:0]    pop_payload,
	output logic [prer_pkg::FAM_W-1:0]        pop_family,
	output logic [prer_pkg::CNT_W-1:0]        count_value,
	output logic [prer_pkg::SUM_W-1:0]        duration_sum,
	output logic [prer_pkg::HW_W-1:0]         high_water
);
	import prer_pkg::*;

	localparam int SLOT_W        = $clog2(RING_DEPTH);
	localparam int PTR_W         = SLOT_W + 1;
	localparam int MAX_CAP       = 1 << ($clog2(RING_DEPTH + 1) - 1);
	localparam int CELL_TOTAL    = MAX_DESCRIPTORS * FAMILIES + 1;
	localparam int OVERFLOW_CELL = MAX_DESCRIPTORS * FAMILIES;
	localparam int CELL_W        = $clog2(CELL_TOTAL);

	// configuration
	logic                 obs_mode_q;
	logic [CAP_CFG_W-1:0] capacity_q;
	logic [RES_CFG_W-1:0] reserve_q;
	logic [DESC_W-1:0]    desc_count_q;

	// ring control
	logic [PTR_W-1:0] wp_q, rp_q, peak_q;
	logic [PTR_W-1:0] cap, cap_m1, pmask, res_eff, occ, room;
	logic             cap_ok, ring_ok, ring_empty;
	logic [SLOT_W-1:0] wr_slot, rd_slot;

	// captured request
	req_t                  req_q;
	logic [FAM_W-1:0]      fam_q;
	logic                  life_q;
	logic [DUR_W-1:0]      dur_q;
	logic [PAYLOAD_W-1:0]  payload_q;
	logic [KIND_W-1:0]     sel_q;
	logic                  cell_ok_q;
	logic [CELL_W-1:0]     cell_addr_q;

	// memories and their read registers
	logic [PAYLOAD_W-1:0] ring_payload_mem [RING_DEPTH];
	logic [FAM_W-1:0]     ring_family_mem  [RING_DEPTH];
	logic [PAYLOAD_W-1:0] ring_pl_rd_q;
	logic [FAM_W-1:0]     ring_fam_rd_q;
	logic [CNT_W-1:0]     agg_cnt_mem [CELL_TOTAL];
	logic [SUM_W-1:0]     agg_sum_mem [CELL_TOTAL];
	logic [CNT_W-1:0]     agg_cnt_rd_q;
	logic [SUM_W-1:0]     agg_sum_rd_q;
	logic [CELL_W-1:0]    clr_idx_q;

	// one row of counters per family
	logic [COUNTER_KINDS-1:0][CNT_W-1:0] fam_ctr_q [FAMILIES];

	logic              no_desc, cell_in_range;
	logic [CELL_W-1:0] cell_rd_addr;
	logic              is_emit, do_agg, ring_we, agg_we, pop_go;
	logic [CELL_W-1:0] agg_waddr;
	logic [CNT_W-1:0]  agg_cnt_new, agg_cnt_wd, ctr_val;
	logic [SUM_W-1:0]  agg_sum_new, agg_sum_wd;
	logic [SUM_W:0]    sum_ext;
	logic [COUNTER_KINDS-1:0] bump;

	result_t              res_d;
	logic [PAYLOAD_W-1:0] pop_pl_d;
	logic [FAM_W-1:0]     pop_fam_d;
	logic [CNT_W-1:0]     cnt_d;
	logic [SUM_W-1:0]     sum_d;
	result_t              result_q;
	logic [PAYLOAD_W-1:0] pop_payload_q;
	logic [FAM_W-1:0]     pop_family_q;
	logic [CNT_W-1:0]     count_q;
	logic [SUM_W-1:0]     sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obs_mode_q   <= 1'b0;
			capacity_q   <= CAPACITY_RESET;
			reserve_q    <= RESERVE_RESET;
			desc_count_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_OBS_MODE:   obs_mode_q   <= cfg_data[0];
				CFG_CAPACITY:   capacity_q   <= cfg_data[CAP_CFG_W-1:0];
				CFG_RESERVE:    reserve_q    <= cfg_data[RES_CFG_W-1:0];
				CFG_DESC_COUNT: desc_count_q <= cfg_data[DESC_W-1:0];
				default:        obs_mode_q   <= obs_mode_q;
			endcase
		end
	end

	// capacity falls back to the largest power of two that fits the ring
	assign cap_ok = (capacity_q >= 5'd2) && (32'(capacity_q) <= 32'(RING_DEPTH))
		&& ((capacity_q & (capacity_q - 5'd1)) == 5'd0);
	assign cap     = cap_ok ? PTR_W'(capacity_q) : PTR_W'(MAX_CAP);
	assign cap_m1  = cap - PTR_W'(1);
	assign pmask   = (cap << 1) - PTR_W'(1);
	assign res_eff = (32'(reserve_q) >= 32'(cap)) ? cap_m1 : PTR_W'(reserve_q);
	assign occ     = (wp_q - rp_q) & pmask;
	assign room    = cap - res_eff;
	assign ring_ok = (occ < cap) && (life_q || occ < room);
	assign ring_empty = occ == '0;
	assign wr_slot = SLOT_W'(wp_q & cap_m1);
	assign rd_slot = SLOT_W'(rp_q & cap_m1);

	// aggregate cell address, taken from the request ports at capture
	assign no_desc = (desc_index == DESC_W'(NO_DESCRIPTOR))
		|| (32'(desc_index) >= 32'(MAX_DESCRIPTORS))
		|| (desc_index >= desc_count_q);
	assign cell_in_range = 32'(cell_index) < 32'(CELL_TOTAL);

	always_comb begin
		if (req_t'(req_type) == REQ_READ_CELL) begin
			cell_rd_addr = cell_in_range ? CELL_W'(cell_index) : '0;
		end else if (no_desc) begin
			cell_rd_addr = CELL_W'(OVERFLOW_CELL);
		end else begin
			cell_rd_addr = CELL_W'({desc_index, family});
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q       <= req_t'(req_type);
			fam_q       <= family;
			life_q      <= lifecycle;
			dur_q       <= duration;
			payload_q   <= payload;
			sel_q       <= counter_sel;
			cell_ok_q   <= cell_in_range;
			cell_addr_q <= cell_rd_addr;
		end
	end

	assign is_emit = req_q == REQ_EMIT;
	assign do_agg  = !life_q && obs_mode_q;
	assign ring_we = cmd.commit && is_emit && !do_agg && ring_ok;
	assign pop_go  = cmd.commit && (req_q == REQ_POP) && !ring_empty;
	assign agg_we  = cmd.clear || (cmd.commit && is_emit && do_agg);

	assign agg_cnt_new = (&agg_cnt_rd_q) ? agg_cnt_rd_q : agg_cnt_rd_q + CNT_W'(1);
	assign sum_ext     = {1'b0, agg_sum_rd_q} + (SUM_W + 1)'(dur_q);
	assign agg_sum_new = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
	assign agg_waddr   = cmd.clear ? clr_idx_q : cell_addr_q;
	assign agg_cnt_wd  = cmd.clear ? '0 : agg_cnt_new;
	assign agg_sum_wd  = cmd.clear ? '0 : agg_sum_new;

	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring_payload_mem[wr_slot] <= payload_q;
			ring_family_mem[wr_slot]  <= fam_q;
		end
		if (cmd.capture) begin
			ring_pl_rd_q  <= ring_payload_mem[rd_slot];
			ring_fam_rd_q <= ring_family_mem[rd_slot];
		end
	end

	always_ff @(posedge clk) begin
		if (agg_we) begin
			agg_cnt_mem[agg_waddr] <= agg_cnt_wd;
			agg_sum_mem[agg_waddr] <= agg_sum_wd;
		end
		if (cmd.capture) begin
			agg_cnt_rd_q <= agg_cnt_mem[cell_rd_addr];
			agg_sum_rd_q <= agg_sum_mem[cell_rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q <= '0;
		end else if (cmd.clear) begin
			clr_idx_q <= clr_idx_q + CELL_W'(1);
		end
	end

	assign status.clear_done = cmd.clear && (clr_idx_q == CELL_W'(CELL_TOTAL - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			rp_q   <= '0;
			peak_q <= '0;
		end else begin
			if (ring_we) begin
				wp_q <= (wp_q + PTR_W'(1)) & pmask;
				if (occ + PTR_W'(1) > peak_q) peak_q <= occ + PTR_W'(1);
			end
			if (pop_go) rp_q <= (rp_q + PTR_W'(1)) & pmask;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int f = 0; f < FAMILIES; f++) begin
				for (int k = 0; k < COUNTER_KINDS; k++) begin
					fam_ctr_q[f][k] <= '0;
				end
			end
		end else if (cmd.commit) begin
			for (int k = 0; k < COUNTER_KINDS; k++) begin
				if (bump[k] && !(&fam_ctr_q[fam_q][k])) begin
					fam_ctr_q[fam_q][k] <= fam_ctr_q[fam_q][k] + CNT_W'(1);
				end
			end
		end
	end

	assign ctr_val = (sel_q < KIND_W'(COUNTER_KINDS)) ? fam_ctr_q[fam_q][sel_q] : '0;

	always_comb begin
		res_d     = RES_READ_DONE;
		pop_pl_d  = '0;
		pop_fam_d = '0;
		cnt_d     = '0;
		sum_d     = '0;
		bump      = '0;
		unique case (req_q)
			REQ_EMIT: begin
				bump[KIND_UPDATES]  = 1'b1;
				bump[KIND_OBSERVED] = 1'b1;
				if (do_agg) begin
					bump[KIND_AGGREGATED] = 1'b1;
					res_d = RES_AGGREGATED;
				end else if (ring_ok) begin
					bump[KIND_EMITTED] = 1'b1;
					res_d = RES_EMITTED;
				end else begin
					bump[KIND_DROPPED] = 1'b1;
					res_d = RES_DROPPED;
				end
			end
			REQ_POP: begin
				if (ring_empty) begin
					res_d = RES_EMPTY;
				end else begin
					res_d     = RES_POPPED;
					pop_pl_d  = ring_pl_rd_q;
					pop_fam_d = ring_fam_rd_q;
				end
			end
			REQ_READ_CNT: cnt_d = ctr_val;
			REQ_READ_CELL: begin
				if (cell_ok_q) begin
					cnt_d = agg_cnt_rd_q;
					sum_d = agg_sum_rd_q;
				end
			end
			default: res_d = RES_READ_DONE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			result_q      <= res_d;
			pop_payload_q <= pop_pl_d;
			pop_family_q  <= pop_fam_d;
			count_q       <= cnt_d;
			sum_q         <= sum_d;
		end
	end

	assign result_code  = result_q;
	assign pop_payload  = pop_payload_q;
	assign pop_family   = pop_family_q;
	assign count_value  = count_q;
	assign duration_sum = sum_q;
	// peak only moves at commit, so it is steady while a result waits
	assign high_water   = HW_W'(peak_q);

`ifndef ASSERT_OFF
	a_peak_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		peak_q >= $past(peak_q))
		else $error("high-water mark decreased");

	a_occ_within_cap: assert property (@(posedge clk) disable iff (!arst_n)
		occ <= cap)
		else $error("ring occupancy above capacity");

	a_clear_no_commit: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.clear && cmd.commit))
		else $error("commit during table clear");
`endif

endmodule

[hdl/priority_reserved_event_ring.sv]
// Telemetry event lane: emit requests go to a ring (detail events stop at capacity minus
// the reserve, lifecycle events may fill it) or, in aggregate mode, fold into a count and
// duration cell; pop and read requests return ring entries, per-family counters and cells.
// Each request passes a capture edge and then a commit edge: the capture edge registers the
// ring and aggregate-table reads, the commit edge does the single read-modify-write of the
// table, pointers and counters and loads the result register; a result waiting in the
// output register holds the commit, and a new request is taken once the previous one has
// committed. After reset the aggregate table is cleared one cell per cycle, all
// MAX_DESCRIPTORS*8+1 cells (129 by default), with in_ready low; configuration writes are
// taken at any time.
module priority_reserved_event_ring #(
	parameter int RING_DEPTH      = prer_pkg::RING_DEPTH_DEF,
	parameter int MAX_DESCRIPTORS = prer_pkg::MAX_DESC_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [prer_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [prer_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [prer_pkg::REQ_W-1:0]        req_type,
	input  logic [prer_pkg::FAM_W-1:0]        family,
	input  logic                              lifecycle,
	input  logic [prer_pkg::DESC_W-1:0]       desc_index,
	input  logic [prer_pkg::DUR_W-1:0]        duration,
	input  logic [prer_pkg::PAYLOAD_W-1:0]    payload,
	input  logic [prer_pkg::KIND_W-1:0]       counter_sel,
	input  logic [prer_pkg::CELL_IDX_W-1:0]   cell_index,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [prer_pkg::RESULT_W-1:0]     result_code,
	output logic [prer_pkg::PAYLOAD_W-1:0]    pop_payload,
	output logic [prer_pkg::FAM_W-1:0]        pop_family,
	output logic [prer_pkg::CNT_W-1:0]        count_value,
	output logic [prer_pkg::SUM_W-1:0]        duration_sum,
	output logic [prer_pkg::HW_W-1:0]         high_water
);
	import prer_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;
	logic       cfg_we;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	prer_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	prer_dp #(
		.RING_DEPTH      (RING_DEPTH),
		.MAX_DESCRIPTORS (MAX_DESCRIPTORS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.req_type     (req_type),
		.family       (family),
		.lifecycle    (lifecycle),
		.desc_index   (desc_index),
		.duration     (duration),
		.payload      (payload),
		.counter_sel  (counter_sel),
		.cell_index   (cell_index),
		.result_code  (result_code),
		.pop_payload  (pop_payload),
		.pop_family   (pop_family),
		.count_value  (count_value),
		.duration_sum (duration_sum),
		.high_water   (high_water)
	);

endmodule

[dv/priority_reserved_event_ring_tb.sv]
`timescale 1ns / 100ps

module priority_reserved_event_ring_tb;
	import prer_pkg::*;

	localparam int RING_SLOTS  = RING_DEPTH_DEF;
	localparam int DESC_SLOTS  = MAX_DESC_DEF;
	localparam int CELL_COUNT  = DESC_SLOTS * FAMILIES + 1;
	localparam int OVERFLOW    = DESC_SLOTS * FAMILIES;
	localparam int STUCK_LIMIT = 4000;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASE_ITEMS = 110;
	localparam int FIXED_SETS  = 9;
	localparam int RANDOM_SETS = 2;

	typedef struct {
		req_t              kind;
		logic [FAM_W-1:0]  family;
		logic              lifecycle;
		logic [DESC_W-1:0] desc_idx;
		logic [DUR_W-1:0]  dur;
		logic [63:0]       payload;
		logic [KIND_W-1:0] counter_sel;
		logic [7:0]        cell_index;
	} lane_req_t;

	typedef struct {
		result_t           code;
		logic [63:0]       pop_payload;
		logic [FAM_W-1:0]  pop_family;
		logic [CNT_W-1:0]  count_value;
		logic [SUM_W-1:0]  duration_sum;
		logic [HW_W-1:0]   high_water;
	} lane_resp_t;

	// mode, ring size, reserve, valid descriptors
	int settings [FIXED_SETS][4] = '{
		'{0, 16, 2, 0}, '{0, 4, 3, 5}, '{1, 8, 0, 16}, '{0, 2, 0, 1}, '{1, 16, 15, 8},
		'{0, 7, 9, 20}, '{1, 2, 1, 3}, '{0, 8, 8, 31}, '{1, 31, 1, 16}
	};

	class lane_scoreboard;
		bit          agg_mode;
		logic [4:0]  cap_reg;
		logic [3:0]  reserve_reg;
		logic [4:0]  desc_reg;
		logic [63:0] ring_pl [RING_SLOTS];
		logic [2:0]  ring_fam [RING_SLOTS];
		int unsigned wr_ptr;
		int unsigned rd_ptr;
		int unsigned peak;
		logic [31:0] fam_cnt [FAMILIES][COUNTER_KINDS];
		logic [31:0] cell_cnt [CELL_COUNT];
		logic [63:0] cell_dur [CELL_COUNT];
		lane_resp_t  responses_due [$];
		int          errors;
		int          checked;

		function new();
			agg_mode    = 1'b0;
			cap_reg     = CAPACITY_RESET;
			reserve_reg = RESERVE_RESET;
			desc_reg    = '0;
			wr_ptr      = 0;
			rd_ptr      = 0;
			peak        = 0;
			errors      = 0;
			checked     = 0;
			foreach (ring_pl[i]) begin
				ring_pl[i]  = '0;
				ring_fam[i] = '0;
			end
			foreach (fam_cnt[f, k])
				fam_cnt[f][k] = '0;
			foreach (cell_cnt[c]) begin
				cell_cnt[c] = '0;
				cell_dur[c] = '0;
			end
		endfunction

		function void write_reg(cfg_reg_t idx, logic [4:0] v);
			case (idx)
				CFG_OBS_MODE: agg_mode = v[0];
				CFG_CAPACITY: cap_reg = v;
				CFG_RESERVE:  reserve_reg = v[3:0];
				default:      desc_reg = v;
			endcase
		endfunction

		// non power-of-two or out-of-range capacity falls back to the full ring
		function int unsigned capacity();
			int unsigned c;
			c = cap_reg;
			if (c >= 2 && c <= RING_SLOTS && (c & (c - 1)) == 0)
				return c;
			c = 1;
			while (c * 2 <= RING_SLOTS)
				c = c * 2;
			return c;
		endfunction

		function int unsigned desc_limit();
			return (desc_reg > DESC_SLOTS) ? DESC_SLOTS : int'(desc_reg);
		endfunction

		function int unsigned occupancy();
			return (wr_ptr - rd_ptr) & (2 * capacity() - 1);
		endfunction

		function int pending();
			return responses_due.size();
		endfunction

		function void bump(logic [2:0] f, kind_t k);
			if (fam_cnt[f][int'(k)] != '1)
				fam_cnt[f][int'(k)]++;
		endfunction

		function void note_request(lane_req_t r);
			lane_resp_t  e;
			int unsigned cap, pmask, occ, slot, cell_no, res;
			cap   = capacity();
			pmask = 2 * cap - 1;
			occ   = (wr_ptr - rd_ptr) & pmask;
			e.code         = RES_READ_DONE;
			e.pop_payload  = '0;
			e.pop_family   = '0;
			e.count_value  = '0;
			e.duration_sum = '0;
			case (r.kind)
				REQ_EMIT: begin
					bump(r.family, KIND_UPDATES);
					bump(r.family, KIND_OBSERVED);
					if (!r.lifecycle && agg_mode) begin
						if (r.desc_idx == NO_DESCRIPTOR || r.desc_idx >= desc_limit())
							cell_no = OVERFLOW;
						else
							cell_no = r.desc_idx * FAMILIES + r.family;
						if (cell_cnt[cell_no] != '1)
							cell_cnt[cell_no]++;
						if (cell_dur[cell_no] > ~64'd0 - {32'd0, r.dur})
							cell_dur[cell_no] = '1;
						else
							cell_dur[cell_no] += {32'd0, r.dur};
						bump(r.family, KIND_AGGREGATED);
						e.code = RES_AGGREGATED;
					end else begin
						res = reserve_reg;
						if (res >= cap)
							res = cap - 1;
						// detail events keep clear of the reserved slots
						if (occ < cap && (r.lifecycle || occ < cap - res)) begin
							slot = wr_ptr & (cap - 1);
							ring_pl[slot]  = r.payload;
							ring_fam[slot] = r.family;
							wr_ptr = (wr_ptr + 1) & pmask;
							if (occ + 1 > peak)
								peak = occ + 1;
							bump(r.family, KIND_EMITTED);
							e.code = RES_EMITTED;
						end else begin
							bump(r.family, KIND_DROPPED);
							e.code = RES_DROPPED;
						end
					end
				end
				REQ_POP: begin
					if (occ == 0) begin
						e.code = RES_EMPTY;
					end else begin
						slot = rd_ptr & (cap - 1);
						e.code        = RES_POPPED;
						e.pop_payload = ring_pl[slot];
						e.pop_family  = ring_fam[slot];
						rd_ptr = (rd_ptr + 1) & pmask;
					end
				end
				REQ_READ_CNT: begin
					if (r.counter_sel < COUNTER_KINDS)
						e.count_value = fam_cnt[r.family][r.counter_sel];
				end
				default: begin
					if (r.cell_index < CELL_COUNT) begin
						e.count_value  = cell_cnt[r.cell_index];
						e.duration_sum = cell_dur[r.cell_index];
					end
				end
			endcase
			e.high_water = peak[4:0];
			responses_due.insert(responses_due.size(), e);
		endfunction

		function void compare(string what, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				$display("%0t: %s expected %0h got %0h", $time, what, want, got);
				errors++;
			end
		endfunction

		function void check_result(logic [2:0] code, logic [63:0] pl, logic [2:0] fam,
				logic [31:0] cnt, logic [63:0] sum, logic [4:0] hw);
			lane_resp_t e;
			if (responses_due.size() == 0) begin
				$display("%0t: result code %0h with no request outstanding", $time, code);
				errors++;
				return;
			end
			e = responses_due.pop_front();
			checked++;
			compare("result_code", 64'(e.code), 64'(code));
			compare("pop_payload", e.pop_payload, pl);
			compare("pop_family", 64'(e.pop_family), 64'(fam));
			compare("count_value", 64'(e.count_value), 64'(cnt));
			compare("duration_sum", e.duration_sum, sum);
			compare("high_water", 64'(e.high_water), 64'(hw));
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [REQ_W-1:0]      req_type = '0;
	logic [FAM_W-1:0]      family = '0;
	logic                  lifecycle = 1'b0;
	logic [DESC_W-1:0]     desc_index = '0;
	logic [DUR_W-1:0]      duration = '0;
	logic [PAYLOAD_W-1:0]  payload = '0;
	logic [KIND_W-1:0]     counter_sel = '0;
	logic [CELL_IDX_W-1:0] cell_index = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [RESULT_W-1:0]   result_code;
	logic [PAYLOAD_W-1:0]  pop_payload;
	logic [FAM_W-1:0]      pop_family;
	logic [CNT_W-1:0]      count_value;
	logic [SUM_W-1:0]      duration_sum;
	logic [HW_W-1:0]       high_water;

	lane_scoreboard lane;
	int  sent = 0;
	int  settings_applied = 0;
	int  stuck_cycles = 0;
	int  hold_tag = 0;
	bit  no_idle = 1'b0;

	priority_reserved_event_ring i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.family       (family),
		.lifecycle    (lifecycle),
		.desc_index   (desc_index),
		.duration     (duration),
		.payload      (payload),
		.counter_sel  (counter_sel),
		.cell_index   (cell_index),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_code  (result_code),
		.pop_payload  (pop_payload),
		.pop_family   (pop_family),
		.count_value  (count_value),
		.duration_sum (duration_sum),
		.high_water   (high_water)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, STUCK_LIMIT);
			$display("Mismatches found");
			$finish;
		end
	end

	// mostly back-to-back, sometimes a short gap, rarely a long gap
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic lane_req_t mk(req_t k, logic [2:0] f, logic life, logic [4:0] d,
			logic [31:0] dur, logic [63:0] pl, logic [2:0] sel, logic [7:0] cell_sel);
		lane_req_t r;
		r.kind        = k;
		r.family      = f;
		r.lifecycle   = life;
		r.desc_idx    = d;
		r.dur         = dur;
		r.payload     = pl;
		r.counter_sel = sel;
		r.cell_index  = cell_sel;
		return r;
	endfunction

	function automatic lane_req_t random_req(req_t k);
		return mk(k, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
			5'($urandom_range(0, 31)), $urandom, {$urandom, $urandom},
			3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
	endfunction

	task automatic send(lane_req_t it);
		int gap;
		gap = pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		req_type    <= it.kind;
		family      <= it.family;
		lifecycle   <= it.lifecycle;
		desc_index  <= it.desc_idx;
		duration    <= it.dur;
		payload     <= it.payload;
		counter_sel <= it.counter_sel;
		cell_index  <= it.cell_index;
		do
			@(posedge clk);
		while (!in_ready);
		lane.note_request(it);
		sent++;
	endtask

	task automatic quiesce();
		in_valid <= 1'b0;
		while (lane.pending() != 0)
			@(posedge clk);
	endtask

	// empty the ring so a capacity change never reinterprets live entries
	task automatic drain_ring();
		while (lane.occupancy() != 0)
			send(random_req(REQ_POP));
		quiesce();
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [4:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		lane.write_reg(idx, v);
	endtask

	task automatic apply_setting(int obs, int cap, int res, int dc);
		write_reg(CFG_OBS_MODE, {4'($urandom_range(0, 15)), 1'(obs)});
		write_reg(CFG_CAPACITY, 5'(cap));
		write_reg(CFG_RESERVE, {1'($urandom_range(0, 1)), 4'(res)});
		write_reg(CFG_DESC_COUNT, 5'(dc));
		cfg_valid <= 1'b0;
		settings_applied++;
	endtask

	task automatic emit_burst(int len);
		lane_req_t   r;
		int unsigned lim;
		lim = lane.desc_limit();
		repeat (len) begin
			r = random_req(REQ_EMIT);
			r.lifecycle = ($urandom_range(0, 2) == 0);
			if (lim > 0 && $urandom_range(0, 3) != 0)
				r.desc_idx = 5'($urandom_range(0, lim - 1));
			if ($urandom_range(0, 19) == 0)
				r.dur = '1;
			send(r);
		end
	endtask

	task automatic run_phase(int n);
		lane_req_t   r;
		int          start, pick;
		int unsigned lim;
		start = sent;
		lim   = lane.desc_limit();
		while (sent - start < n) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				emit_burst($urandom_range(1, 2 * lane.capacity() + 2));
			end else if (pick < 75) begin
				repeat ($urandom_range(1, lane.capacity() + 2))
					send(random_req(REQ_POP));
			end else if (pick < 87) begin
				r = random_req(REQ_READ_CNT);
				if ($urandom_range(0, 6) != 0)
					r.counter_sel = 3'($urandom_range(0, COUNTER_KINDS - 1));
				send(r);
			end else begin
				r = random_req(REQ_READ_CELL);
				pick = $urandom_range(0, 9);
				if (pick < 6 && lim > 0)
					r.cell_index = 8'($urandom_range(0, lim - 1) * FAMILIES + $urandom_range(0, 7));
				else if (pick < 8)
					r.cell_index = 8'(OVERFLOW);
				send(r);
			end
		end
	endtask

	initial begin : receiver
		int stall_left;
		int hold_seen;
		int g;
		stall_left = 0;
		hold_seen  = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready)
				lane.check_result(result_code, pop_payload, pop_family, count_value,
					duration_sum, high_water);
			if (hold_tag != hold_seen) begin
				hold_seen  = hold_tag;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				g = pick_gap();
				out_ready  <= (g == 0);
				stall_left = (g > 0) ? g - 1 : 0;
			end
		end
	end

	initial begin : stimulus
		lane = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values: empty ring, bad selectors, field extremes
		send(mk(REQ_POP, 3'd0, 1'b0, 5'd0, 32'd0, '0, 3'd0, 8'd0));
		send(mk(REQ_READ_CNT, 3'd3, 1'b1, 5'd31, '1, '1, 3'd7, 8'd0));
		send(mk(REQ_READ_CELL, 3'd0, 1'b0, 5'd0, 32'd0, '0, 3'd0, 8'd255));
		send(mk(REQ_EMIT, 3'd7, 1'b1, 5'd31, '1, '1, 3'd7, 8'd255));
		send(mk(REQ_EMIT, 3'd0, 1'b0, 5'd0, 32'd0, '0, 3'd0, 8'd0));
		repeat (3) send(mk(REQ_POP, 3'd0, 1'b0, 5'd0, 32'd0, '0, 3'd0, 8'd0));
		quiesce();

		// aggregate mode, oversized reserve and descriptor count, smallest ring
		apply_setting(1, 2, 15, 31);
		send(mk(REQ_EMIT, 3'd7, 1'b0, 5'd15, '1, 64'h0123_4567_89ab_cdef, 3'd0, 8'd0));
		send(mk(REQ_EMIT, 3'd5, 1'b0, 5'd16, 32'h8000_0001, '0, 3'd0, 8'd0));
		send(mk(REQ_EMIT, 3'd5, 1'b0, 5'd31, 32'd0, '0, 3'd0, 8'd0));
		send(mk(REQ_READ_CELL, 3'd0, 1'b0, 5'd0, 32'd0, '0, 3'd0, 8'd127));
		send(mk(REQ_READ_CELL, 3'd0, 1'b0, 5'd0, 32'd0, '0, 3'd0, 8'd128));
		repeat (3) send(mk(REQ_EMIT, 3'd2, 1'b1, 5'd0, 32'd5, {$urandom, $urandom}, 3'd0, 8'd0));
		send(mk(REQ_READ_CNT, 3'd2, 1'b0, 5'd0, 32'd0, '0, KIND_DROPPED, 8'd0));
		send(mk(REQ_READ_CNT, 3'd5, 1'b0, 5'd0, 32'd0, '0, KIND_AGGREGATED, 8'd0));
		drain_ring();

		// detail events stop short of the reserve, a lifecycle event goes into the reserve
		apply_setting(0, 4, 2, 0);
		repeat (3) send(mk(REQ_EMIT, 3'd1, 1'b0, 5'd3, 32'd9, {$urandom, $urandom}, 3'd0, 8'd0));
		send(mk(REQ_EMIT, 3'd6, 1'b1, 5'd3, 32'd9, {$urandom, $urandom}, 3'd0, 8'd0));
		send(mk(REQ_READ_CNT, 3'd1, 1'b0, 5'd0, 32'd0, '0, KIND_UPDATES, 8'd0));
		drain_ring();

		for (int p = 0; p < FIXED_SETS + RANDOM_SETS; p++) begin
			if (p < FIXED_SETS)
				apply_setting(settings[p][0], settings[p][1], settings[p][2], settings[p][3]);
			else
				apply_setting($urandom_range(0, 1), $urandom_range(0, 31),
					$urandom_range(0, 15), $urandom_range(0, 31));
			no_idle <= (p == 2);
			if (p == 0) begin
				// output side stalls long enough for the lane to back up
				hold_tag <= hold_tag + 1;
				emit_burst(40);
			end
			run_phase(PHASE_ITEMS);
			drain_ring();
		end

		quiesce();
		repeat (20) @(posedge clk);
		$display("Run covered %0d requests and %0d checked results over %0d register settings",
			sent, lane.checked, settings_applied);
		if (lane.errors == 0 && lane.pending() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
